// File: sv/iapm_pkg.sv
// shared constants, types and config layout for the inverse affine pixel mapper
package iapm_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_BITS   = 20;
  localparam int SIZE_BITS   = 13;
  localparam int Q_BITS      = FRAC_BITS + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_XX      = 3'd0,
    REG_COEF_XY      = 3'd1,
    REG_COEF_XT      = 3'd2,
    REG_COEF_YX      = 3'd3,
    REG_COEF_YY      = 3'd4,
    REG_COEF_YT      = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_xx;
    logic signed [COEF_BITS-1:0] coef_xy;
    logic signed [COEF_BITS-1:0] coef_xt;
    logic signed [COEF_BITS-1:0] coef_yx;
    logic signed [COEF_BITS-1:0] coef_yy;
    logic signed [COEF_BITS-1:0] coef_yt;
    logic [SIZE_BITS-1:0]        image_width;
    logic [SIZE_BITS-1:0]        image_height;
  } cfg_t;

  // normalized coordinates handed from front to back
  typedef struct packed {
    logic [Q_BITS-1:0] u;
    logic [Q_BITS-1:0] r;
  } norm_t;

  // queue status seen by the top level
  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCNT_BITS-1:0] count;
  } queue_stat_t;

endpackage

// File: sv/iapm_front.sv
// front end: accepts coordinates and normalizes them with pipelined dividers
module iapm_front import iapm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] out_col,
  input  logic [COORD_BITS-1:0] out_row,
  output logic                  push,
  output norm_t                 push_data
);

  logic                 valid [0:Q_BITS];
  logic [SIZE_BITS-1:0] rem_u [0:Q_BITS];
  logic [SIZE_BITS-1:0] rem_r [0:Q_BITS];
  logic [Q_BITS-1:0]    q_u   [0:Q_BITS];
  logic [Q_BITS-1:0]    q_r   [0:Q_BITS];
  logic                 ovf_u [0:Q_BITS];
  logic                 ovf_r [0:Q_BITS];
  logic                 nb_u  [0:Q_BITS];
  logic                 nb_r  [0:Q_BITS];

  // first stage: saturation check and initial partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_u[0] <= {2'b00, out_col} >= {cfg.image_width, 1'b0};
      ovf_r[0] <= {2'b00, out_row} >= {cfg.image_height, 1'b0};
      rem_u[0] <= {2'b00, out_col[COORD_BITS-1:1]};
      rem_r[0] <= {2'b00, out_row[COORD_BITS-1:1]};
      nb_u[0]  <= out_col[0];
      nb_r[0]  <= out_row[0];
      q_u[0]   <= '0;
      q_r[0]   <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= Q_BITS; k++) begin : g_div
    logic [SIZE_BITS:0] tu, tr, du, dr;
    logic               geu, ger;

    always_comb begin
      tu  = {rem_u[k-1], (k == 1) ? nb_u[k-1] : 1'b0};
      tr  = {rem_r[k-1], (k == 1) ? nb_r[k-1] : 1'b0};
      du  = tu - {1'b0, cfg.image_width};
      dr  = tr - {1'b0, cfg.image_height};
      geu = tu >= {1'b0, cfg.image_width};
      ger = tr >= {1'b0, cfg.image_height};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_u[k] <= geu ? du[SIZE_BITS-1:0] : tu[SIZE_BITS-1:0];
        rem_r[k] <= ger ? dr[SIZE_BITS-1:0] : tr[SIZE_BITS-1:0];
        q_u[k]   <= {q_u[k-1][Q_BITS-2:0], geu};
        q_r[k]   <= {q_r[k-1][Q_BITS-2:0], ger};
        ovf_u[k] <= ovf_u[k-1];
        ovf_r[k] <= ovf_r[k-1];
        nb_u[k]  <= nb_u[k-1];
        nb_r[k]  <= nb_r[k-1];
      end
    end
  end

  assign push        = en & valid[Q_BITS];
  assign push_data.u = ovf_u[Q_BITS] ? '1 : q_u[Q_BITS];
  assign push_data.r = ovf_r[Q_BITS] ? '1 : q_r[Q_BITS];

endmodule

// File: sv/iapm_queue.sv
// small fifo between the normalizing front and the mapping back
module iapm_queue import iapm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  norm_t       push_data,
  input  logic        pop,
  output norm_t       head,
  output queue_stat_t stat
);

  norm_t                mem [0:QUEUE_DEPTH-1];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head       = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = count == QCNT_BITS'(QUEUE_DEPTH);
  assign stat.empty = count == '0;

endmodule

// File: sv/iapm_back.sv
// back end: affine transform, range check and scaling to source pixels
module iapm_back import iapm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  avail,
  input  norm_t                 head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  in_range,
  output logic [COORD_BITS-1:0] src_x,
  output logic [COORD_BITS-1:0] src_y
);

  localparam int PW = COEF_BITS + FRAC_BITS + 2;
  localparam int FW = COEF_BITS + 2;
  localparam int SW = COEF_BITS + 4;
  localparam int MW = Q_BITS + SIZE_BITS;
  localparam int DW = SIZE_BITS + 1;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic en;
  logic v1, v2, v3, v4;

  assign en  = !v4 || out_ready;
  assign pop = en && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= avail;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: the four matrix products
  logic signed [FRAC_BITS+1:0] us, vs;
  logic signed [PW-1:0]        pxu, pxv, pyu, pyv;

  assign us = $signed({1'b0, head.u});
  assign vs = $signed((FRAC_BITS+2)'(1) << FRAC_BITS) - $signed({1'b0, head.r});

  always_ff @(posedge clk) begin
    if (en) begin
      pxu <= cfg.coef_xx * us;
      pxv <= cfg.coef_xy * vs;
      pyu <= cfg.coef_yx * us;
      pyv <= cfg.coef_yy * vs;
    end
  end

  // stage 2: floored products summed with translation, range check
  logic signed [SW-1:0] xs, ys, yinv;
  logic                 inr2;
  logic [Q_BITS-1:0]    xq, yq;

  always_comb begin
    xs = SW'(FW'(pxu >>> FRAC_BITS)) + SW'(FW'(pxv >>> FRAC_BITS)) + SW'(cfg.coef_xt);
    ys = SW'(FW'(pyu >>> FRAC_BITS)) + SW'(FW'(pyv >>> FRAC_BITS)) + SW'(cfg.coef_yt);
    yinv = ONE_S - ys;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr2 <= (xs >= 0) && (xs <= ONE_S) && (ys >= 0) && (ys <= ONE_S)
              && (cfg.image_width != '0) && (cfg.image_height != '0);
      xq   <= xs[Q_BITS-1:0];
      yq   <= yinv[Q_BITS-1:0];
    end
  end

  // stage 3: scale by image size
  logic [MW-1:0] mx, my;
  logic          inr3;

  always_ff @(posedge clk) begin
    if (en) begin
      mx   <= MW'(xq) * MW'(cfg.image_width);
      my   <= MW'(yq) * MW'(cfg.image_height);
      inr3 <= inr2;
    end
  end

  // stage 4: clamp to last column and row, output register
  logic [DW-1:0]        sx, sy;
  logic [SIZE_BITS-1:0] wm1, hm1;

  always_comb begin
    wm1 = cfg.image_width - 1'b1;
    hm1 = cfg.image_height - 1'b1;
    sx  = mx[MW-1:FRAC_BITS];
    sy  = my[MW-1:FRAC_BITS];
    if (sx > {1'b0, wm1}) sx = {1'b0, wm1};
    if (sy > {1'b0, hm1}) sy = {1'b0, hm1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_range <= inr3;
      src_x    <= inr3 ? sx[COORD_BITS-1:0] : '0;
      src_y    <= inr3 ? sy[COORD_BITS-1:0] : '0;
    end
  end

  assign out_valid = v4;

endmodule

// File: sv/inverse_affine_pixel_mapper.sv
// top level of the inverse affine pixel mapper (nearest neighbor warp)
// Maps each output pixel (out_col, out_row) back to a source pixel through a
// software-written 2x3 affine matrix in signed Q3.16. One request is taken
// per clock while the queue has room, and one result comes out per request,
// in order; each passes the normalizing dividers, the queue memory and the
// transform pipeline in turn. The latency is set by the two restoring
// dividers, one quotient bit per stage, that form col/width and row/height.
// A four-entry queue decouples the dividers from the transform stages so a
// stalled output only blocks the input once the queue is full.
// Configuration writes take effect at once and are to be made while idle.
module inverse_affine_pixel_mapper import iapm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   out_col,
  input  logic [COORD_BITS-1:0]   out_row,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    in_range,
  output logic [COORD_BITS-1:0]   src_x,
  output logic [COORD_BITS-1:0]   src_y
);

  cfg_t        cfg;
  logic        push, pop;
  norm_t       push_data, head;
  queue_stat_t qstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx      <= COEF_BITS'(1) << FRAC_BITS;
      cfg.coef_xy      <= '0;
      cfg.coef_xt      <= '0;
      cfg.coef_yx      <= '0;
      cfg.coef_yy      <= COEF_BITS'(1) << FRAC_BITS;
      cfg.coef_yt      <= '0;
      cfg.image_width  <= SIZE_BITS'(640);
      cfg.image_height <= SIZE_BITS'(480);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_COEF_XX:      cfg.coef_xx      <= cfg_data;
        REG_COEF_XY:      cfg.coef_xy      <= cfg_data;
        REG_COEF_XT:      cfg.coef_xt      <= cfg_data;
        REG_COEF_YX:      cfg.coef_yx      <= cfg_data;
        REG_COEF_YY:      cfg.coef_yy      <= cfg_data;
        REG_COEF_YT:      cfg.coef_yt      <= cfg_data;
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[SIZE_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front advances whenever the queue has room
  assign in_ready = !qstat.full;

  iapm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .en        (in_ready),
    .in_valid  (in_valid),
    .out_col   (out_col),
    .out_row   (out_row),
    .push      (push),
    .push_data (push_data)
  );

  iapm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  iapm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .avail     (!qstat.empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_range  (in_range),
    .src_x     (src_x),
    .src_y     (src_y)
  );

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // black pixel requests carry zero coordinates
  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |-> (src_x == '0 && src_y == '0))
    else $error("out of range result with nonzero coordinates");

  // a full queue holds its count unless the back end drains it
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (qstat.full && !pop) |=> qstat.full)
    else $error("full queue changed without a pop");

endmodule

// File: bench/tb_inverse_affine_pixel_mapper.sv
// testbench for the inverse affine pixel mapper: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module tb_inverse_affine_pixel_mapper;
  import iapm_pkg::*;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam int DRAIN_WAIT = 40;       // drain margin beyond the pipeline latency
  localparam int WATCH_MAX  = 5000;     // idle cycles before giving up

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pixel_req_t;

  typedef struct packed {
    logic                  hit;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
  } src_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COEF_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] out_col = '0;
  logic [COORD_BITS-1:0] out_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic in_range;
  logic [COORD_BITS-1:0] src_x;
  logic [COORD_BITS-1:0] src_y;

  inverse_affine_pixel_mapper DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .out_col(out_col), .out_row(out_row),
    .out_valid(out_valid), .out_ready(out_ready), .in_range(in_range),
    .src_x(src_x), .src_y(src_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the matrix and image size
  cfg_t       shadow_cfg;
  pixel_req_t pending_reqs[$];
  src_pixel_t expected_pixels[$];
  int         error_count = 0;
  bit         calm_phase = 1'b0;   // no idling near the end
  bit         hold_sender = 1'b0;
  int         sink_hold = 0;       // long receiver hold-off in cycles

  // normalize a coordinate to Q1.16, saturating
  function automatic longint norm_coord(longint c, longint size);
    longint q;
    q = (c << FRAC_BITS) / size;
    return (q > 2 * ONE - 1) ? 2 * ONE - 1 : q;
  endfunction

  // floor of a product scaled down by the fraction bits
  function automatic longint floor_q(longint a);
    return a >>> FRAC_BITS;
  endfunction

  function automatic src_pixel_t map_pixel(pixel_req_t req);
    src_pixel_t res;
    longint w, h, u, v, x, y, sx, sy;
    res = '0;
    w = shadow_cfg.image_width;
    h = shadow_cfg.image_height;
    if (w == 0 || h == 0) return res;
    u = norm_coord(req.col, w);
    v = ONE - norm_coord(req.row, h);
    x = floor_q(longint'(shadow_cfg.coef_xx) * u) + floor_q(longint'(shadow_cfg.coef_xy) * v)
        + longint'(shadow_cfg.coef_xt);
    y = floor_q(longint'(shadow_cfg.coef_yx) * u) + floor_q(longint'(shadow_cfg.coef_yy) * v)
        + longint'(shadow_cfg.coef_yt);
    if (x < 0 || x > ONE || y < 0 || y > ONE) return res;
    sx = (x * w) >> FRAC_BITS;
    sy = ((ONE - y) * h) >> FRAC_BITS;
    if (sx > w - 1) sx = w - 1;
    if (sy > h - 1) sy = h - 1;
    res.hit = 1'b1;
    res.sx = sx[COORD_BITS-1:0];
    res.sy = sy[COORD_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error %0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // driver: offers queued requests, with random idle bursts
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(map_pixel(pixel_req_t'{out_col, out_row}));
        void'(pending_reqs.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > (in_valid && in_ready ? 0 : 0) && !hold_sender
                     && pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          out_col <= pending_reqs[0].col;
          out_row <= pending_reqs[0].row;
          if (!calm_phase && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result with the oldest expectation
  int sink_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("error %0t: result with nothing expected", $time);
          error_count++;
        end else begin
          src_pixel_t want;
          want = expected_pixels.pop_front();
          if (in_range !== want.hit) report_mismatch("in_range", in_range, want.hit);
          if (src_x !== want.sx) report_mismatch("src_x", src_x, want.sx);
          if (src_y !== want.sy) report_mismatch("src_y", src_y, want.sy);
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 8);
      end
    end
  end

  // watchdog: cycles with no accepted request or result
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_MAX) begin
      $display("inverse_affine_pixel_mapper: mismatch");
      $finish;
    end
  end

  // one write strobe per call, released before the next call raises it again
  task automatic write_reg(cfg_idx_t idx, logic [COEF_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_XX: shadow_cfg.coef_xx = val;
      REG_COEF_XY: shadow_cfg.coef_xy = val;
      REG_COEF_XT: shadow_cfg.coef_xt = val;
      REG_COEF_YX: shadow_cfg.coef_yx = val;
      REG_COEF_YY: shadow_cfg.coef_yy = val;
      REG_COEF_YT: shadow_cfg.coef_yt = val;
      REG_IMAGE_WIDTH: shadow_cfg.image_width = val[SIZE_BITS-1:0];
      default: shadow_cfg.image_height = val[SIZE_BITS-1:0];
    endcase
  endtask

  // waits until the block has drained
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_pixels.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_matrix(int xx, int xy, int xt, int yx, int yy, int yt, int w, int h);
    write_reg(REG_COEF_XX, xx[COEF_BITS-1:0]);
    write_reg(REG_COEF_XY, xy[COEF_BITS-1:0]);
    write_reg(REG_COEF_XT, xt[COEF_BITS-1:0]);
    write_reg(REG_COEF_YX, yx[COEF_BITS-1:0]);
    write_reg(REG_COEF_YY, yy[COEF_BITS-1:0]);
    write_reg(REG_COEF_YT, yt[COEF_BITS-1:0]);
    write_reg(REG_IMAGE_WIDTH, w[COEF_BITS-1:0]);
    write_reg(REG_IMAGE_HEIGHT, h[COEF_BITS-1:0]);
  endtask

  function automatic int rand_coef();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2 * ONE) - ONE;          // near rotations
      1: return $urandom_range(0, 1048575) - 524288;        // full range
      2: return ($urandom_range(0, 1)) ? 524287 : -524288;  // extremes
      default: return $urandom_range(0, ONE);
    endcase
  endfunction

  function automatic int rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 1 : 4096;
      1: return $urandom_range(4097, 8191);   // above 4096, masked output
      2: return 0;
      default: return $urandom_range(1, 700);
    endcase
  endfunction

  // mostly in-image pixels, some anywhere in the field range
  task automatic queue_random(int n);
    pixel_req_t req;
    int w, h;
    w = (shadow_cfg.image_width == 0) ? 1 : shadow_cfg.image_width;
    h = (shadow_cfg.image_height == 0) ? 1 : shadow_cfg.image_height;
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) begin
        req.col = COORD_BITS'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
        req.row = COORD_BITS'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
      end else begin
        req.col = COORD_BITS'($urandom);
        req.row = COORD_BITS'($urandom);
      end
      pending_reqs.push_back(req);
    end
  endtask

  initial begin
    shadow_cfg = '{coef_xx: ONE, coef_xy: 0, coef_xt: 0, coef_yx: 0, coef_yy: ONE,
                   coef_yt: 0, image_width: 640, image_height: 480};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset identity, corners, field extremes
    pending_reqs.push_back('{0, 0});
    pending_reqs.push_back('{639, 479});
    pending_reqs.push_back('{4095, 4095});
    pending_reqs.push_back('{320, 240});
    pending_reqs.push_back('{4095, 0});
    wait_idle();
    // source exactly on the far edge: x = 1 and y = 0 get clamped
    load_matrix(0, 0, ONE, 0, 0, 0, 640, 480);
    pending_reqs.push_back('{5, 5});
    wait_idle();
    // 180 degree rotation, partly out of range with offsets
    load_matrix(-ONE, 0, ONE, 0, -ONE, ONE, 4096, 4096);
    pending_reqs.push_back('{0, 0});
    pending_reqs.push_back('{4095, 4095});
    pending_reqs.push_back('{2048, 1});
    wait_idle();
    // coefficient extremes
    load_matrix(524287, -524288, -524288, -524288, 524287, 524287, 1, 1);
    pending_reqs.push_back('{0, 0});
    pending_reqs.push_back('{4095, 4095});
    wait_idle();
    // zero width and zero height
    load_matrix(ONE, 0, 0, 0, ONE, 0, 0, 100);
    pending_reqs.push_back('{3, 3});
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, COEF_BITS'(100));
    write_reg(REG_IMAGE_HEIGHT, COEF_BITS'(0));
    pending_reqs.push_back('{3, 3});
    wait_idle();
    // size above 4096
    load_matrix(ONE / 2, 0, ONE / 4, 0, ONE / 2, ONE / 4, 8191, 5000);
    pending_reqs.push_back('{4095, 4095});
    pending_reqs.push_back('{0, 4095});
    wait_idle();

    // random phases with fresh settings
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) load_matrix(ONE, 0, 0, 0, ONE, 0, 320, 200);
      else load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef(), rand_coef(), rand_size(), rand_size());
      if (ph == 10) calm_phase = 1'b1;
      queue_random(55);
      if (ph == 3) sink_hold = 120;   // receiver stalls while requests keep coming
      if (ph == 6) begin
        while (pending_reqs.size() > 30) @(posedge clk);
        hold_sender = 1'b1;           // sender pauses until everything drained
        while (in_valid || expected_pixels.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("inverse_affine_pixel_mapper: match");
    end else begin
      $display("inverse_affine_pixel_mapper: mismatch");
    end
    $finish;
  end
endmodule
